/* src/sfas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_pkg
// Shared constants, opcodes, register indexes and control types of the
// sprite frame animation sequencer.
// ----------------------------------------------------------------------------
package sfas_pkg;

	localparam int MaxFramesDef = 256;
	localparam int TickWidthDef = 16;

	// Hard ceiling of the strip length and fixed field widths
	localparam int FrameCapHw = 256;
	localparam int TickW      = 16;
	localparam int AccW       = 32;
	localparam int PeriodW    = 16;
	localparam int CountW     = 9;
	localparam int FrameW     = 8;
	localparam int OpW        = 2;

	// Configuration port
	localparam int AddrW = 5;
	localparam int DataW = 32;
	localparam int RegIdxW = 3;

	// Divider: quotient bits resolved per cycle
	localparam int DivBitsPerCycle = 2;
	localparam int DivIters        = AccW / DivBitsPerCycle;

	localparam logic [OpW-1:0] OP_TICK     = 2'd0;
	localparam logic [OpW-1:0] OP_REWIND   = 2'd1;
	localparam logic [OpW-1:0] OP_JUMP_END = 2'd2;
	localparam logic [OpW-1:0] OP_SET_DIR  = 2'd3;

	localparam logic [RegIdxW-1:0] REG_ENABLED       = 3'd0;
	localparam logic [RegIdxW-1:0] REG_FRAME_PERIOD  = 3'd1;
	localparam logic [RegIdxW-1:0] REG_FRAME_COUNT   = 3'd2;
	localparam logic [RegIdxW-1:0] REG_REPEAT_MODE   = 3'd3;
	localparam logic [RegIdxW-1:0] REG_BOUNCE_MODE   = 3'd4;
	localparam logic [RegIdxW-1:0] REG_VANISH_ON_END = 3'd5;

	typedef struct packed {
		logic               enabled;
		logic [PeriodW-1:0] frame_period;
		logic [CountW-1:0]  frame_count;
		logic               repeat_mode;
		logic               bounce_mode;
		logic               vanish_on_end;
	} cfg_t;

	typedef struct packed {
		logic load_item;
		logic eval;
		logic div_load_acc;
		logic div_step;
		logic acc_done;
		logic div_load_mod;
		logic step_commit;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic oneshot;
	} sts_t;

endpackage

/* src/sfas_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_if
// Valid/ready channels of the sequencer: command items in, frame results out.
// ----------------------------------------------------------------------------
interface sfas_in_if;
	logic                        valid;
	logic                        ready;
	logic [sfas_pkg::OpW-1:0]    opcode;
	logic [sfas_pkg::TickW-1:0]  elapsed_ticks;
	logic                        direction_forward;

	modport source(output valid, opcode, elapsed_ticks, direction_forward, input ready);
	modport sink(input valid, opcode, elapsed_ticks, direction_forward, output ready);
endinterface

interface sfas_out_if;
	logic                        valid;
	logic                        ready;
	logic [sfas_pkg::FrameW-1:0] frame_index;
	logic                        finished;
	logic                        vanish_request;
	logic                        frame_updated;

	modport source(output valid, frame_index, finished, vanish_request, frame_updated,
		input ready);
	modport sink(input valid, frame_index, finished, vanish_request, frame_updated,
		output ready);
endinterface

/* src/sfas_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_regs
// APB configuration registers, one per 32-bit word.
// ----------------------------------------------------------------------------
module sfas_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfas_pkg::AddrW-1:0]  paddr,
	input  logic [sfas_pkg::DataW-1:0]  pwdata,
	output logic [sfas_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output sfas_pkg::cfg_t              cfg
);

	sfas_pkg::cfg_t                cfg_q;
	logic [sfas_pkg::RegIdxW-1:0]  idx;
	logic                          wr_en;

	assign idx    = paddr[sfas_pkg::AddrW-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled       <= 1'b0;
			cfg_q.frame_period  <= sfas_pkg::PeriodW'(1);
			cfg_q.frame_count   <= '0;
			cfg_q.repeat_mode   <= 1'b0;
			cfg_q.bounce_mode   <= 1'b0;
			cfg_q.vanish_on_end <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				sfas_pkg::REG_ENABLED:       cfg_q.enabled       <= pwdata[0];
				sfas_pkg::REG_FRAME_PERIOD:  cfg_q.frame_period  <= pwdata[sfas_pkg::PeriodW-1:0];
				sfas_pkg::REG_FRAME_COUNT:   cfg_q.frame_count   <= pwdata[sfas_pkg::CountW-1:0];
				sfas_pkg::REG_REPEAT_MODE:   cfg_q.repeat_mode   <= pwdata[0];
				sfas_pkg::REG_BOUNCE_MODE:   cfg_q.bounce_mode   <= pwdata[0];
				sfas_pkg::REG_VANISH_ON_END: cfg_q.vanish_on_end <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			sfas_pkg::REG_ENABLED:       prdata[0] = cfg_q.enabled;
			sfas_pkg::REG_FRAME_PERIOD:  prdata[sfas_pkg::PeriodW-1:0] = cfg_q.frame_period;
			sfas_pkg::REG_FRAME_COUNT:   prdata[sfas_pkg::CountW-1:0] = cfg_q.frame_count;
			sfas_pkg::REG_REPEAT_MODE:   prdata[0] = cfg_q.repeat_mode;
			sfas_pkg::REG_BOUNCE_MODE:   prdata[0] = cfg_q.bounce_mode;
			sfas_pkg::REG_VANISH_ON_END: prdata[0] = cfg_q.vanish_on_end;
			default: prdata = '0;
		endcase
	end

endmodule

/* src/sfas_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_ctrl
// Sequencer state machine: accepts an item, runs the shared divider once or
// twice for ticks that cross a frame period, then hands the result out.
// ----------------------------------------------------------------------------
module sfas_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  sfas_pkg::sts_t sts,
	output sfas_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_DIV1 = 3'd2;
	localparam logic [2:0] S_MOD  = 3'd3;
	localparam logic [2:0] S_DIV2 = 3'd4;
	localparam logic [2:0] S_STEP = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	localparam int CntW = $clog2(sfas_pkg::DivIters);
	localparam logic [CntW-1:0] CntLast = CntW'(sfas_pkg::DivIters - 1);

	logic [2:0]      state_q;
	logic [2:0]      state_d;
	logic [CntW-1:0] cnt_q;
	logic            out_valid_q;
	logic            div_end;

	assign div_end   = (cnt_q == CntLast);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.need_div) begin
					cmd.div_load_acc = 1'b1;
					state_d          = S_DIV1;
				end else begin
					cmd.eval = 1'b1;
					state_d  = S_EMIT;
				end
			end
			S_DIV1: begin
				cmd.div_step = 1'b1;
				if (div_end) begin
					cmd.acc_done = 1'b1;
					state_d      = sts.oneshot ? S_STEP : S_MOD;
				end
			end
			S_MOD: begin
				cmd.div_load_mod = 1'b1;
				state_d          = S_DIV2;
			end
			S_DIV2: begin
				cmd.div_step = 1'b1;
				if (div_end) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step_commit = 1'b1;
				state_d         = S_EMIT;
			end
			S_EMIT: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_load_acc || cmd.div_load_mod) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CntW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/sfas_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_dpath
// Animation state, time accumulator, shared restoring divider and the frame
// stepping logic for bounce, repeat and one-shot play.
// ----------------------------------------------------------------------------
module sfas_dpath #(
	parameter int MAX_FRAMES = sfas_pkg::MaxFramesDef,
	parameter int TICK_WIDTH = sfas_pkg::TickWidthDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sfas_pkg::cfg_t               cfg,
	input  sfas_pkg::cmd_t               cmd,
	output sfas_pkg::sts_t               sts,
	input  logic [sfas_pkg::OpW-1:0]     opcode,
	input  logic [sfas_pkg::TickW-1:0]   elapsed_ticks,
	input  logic                         direction_forward,
	output logic [sfas_pkg::FrameW-1:0]  frame_index,
	output logic                         finished,
	output logic                         vanish_request,
	output logic                         frame_updated
);

	localparam int TickW   = sfas_pkg::TickW;
	localparam int AccW    = sfas_pkg::AccW;
	localparam int PerW    = sfas_pkg::PeriodW;
	localparam int CntW    = sfas_pkg::CountW;
	localparam int FrW     = sfas_pkg::FrameW;
	localparam int CapInt  = (MAX_FRAMES < sfas_pkg::FrameCapHw) ? MAX_FRAMES
		: sfas_pkg::FrameCapHw;
	localparam logic [CntW-1:0] CapN = CntW'(CapInt);
	localparam int TwEff   = (TICK_WIDTH < TickW) ? TICK_WIDTH : TickW;
	localparam logic [TickW-1:0] TickMask = TickW'((64'd1 << TwEff) - 64'd1);

	// item and animation state
	logic [sfas_pkg::OpW-1:0] op_q;
	logic [TickW-1:0]         elapsed_q;
	logic                     dir_q;
	logic [AccW-1:0]          time_accum_q;
	logic [FrW-1:0]           frame_q;
	logic                     fwd_q;
	logic                     done_q;
	logic                     upd_q;
	logic                     vanish_q;
	logic [AccW-1:0]          steps_q;

	// divider
	logic [AccW-1:0] dq_q;
	logic [PerW-1:0] rem_q;
	logic [PerW-1:0] div_q;
	logic [AccW-1:0] quot_nx;
	logic [PerW-1:0] rem_nx;
	logic [PerW:0]   trial;

	// output register
	logic [FrW-1:0] out_frame_q;
	logic           out_finished_q;
	logic           out_vanish_q;
	logic           out_updated_q;

	// decode
	logic [CntW-1:0] n;
	logic [CntW-1:0] last_w;
	logic [FrW-1:0]  last8;
	logic [CntW-1:0] cyc;
	logic [PerW-1:0] per;
	logic            oneshot;
	logic            ended;
	logic            tick_live;
	logic [AccW:0]   acc_sum;
	logic [AccW-1:0] acc;

	// stepping
	logic [FrW-1:0]  cur;
	logic [CntW-1:0] r9;
	logic            fwd0;
	logic [CntW-1:0] ph;
	logic [CntW:0]   ph_sum;
	logic [CntW-1:0] ph2;
	logic [CntW-1:0] back_pos;
	logic [CntW:0]   rep_sum;
	logic [CntW:0]   rep_red;
	logic [FrW-1:0]  gap;
	logic [FrW-1:0]  new_frame;
	logic            new_fwd;

	assign n       = (cfg.frame_count > CapN) ? CapN : cfg.frame_count;
	assign last_w  = n - CntW'(1);
	assign last8   = last_w[FrW-1:0];
	assign cyc     = {last8, 1'b0};
	assign per     = (cfg.frame_period == '0) ? PerW'(1) : cfg.frame_period;
	assign oneshot = !cfg.bounce_mode && !cfg.repeat_mode;

	assign ended = (n < CntW'(2))
		|| (oneshot && fwd_q && ({1'b0, frame_q} >= last_w))
		|| (oneshot && !fwd_q && (frame_q == '0));

	assign tick_live = (op_q == sfas_pkg::OP_TICK) && cfg.enabled && (elapsed_q != '0);
	assign acc_sum   = {1'b0, time_accum_q} + (AccW+1)'(elapsed_q);
	// saturate at all ones
	assign acc       = acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];

	assign sts.need_div = tick_live && !ended && (acc > AccW'(per));
	assign sts.oneshot  = oneshot;

	// restoring division, DivBitsPerCycle quotient bits per cycle
	always_comb begin
		rem_nx  = rem_q;
		quot_nx = dq_q;
		trial   = '0;
		for (int i = 0; i < sfas_pkg::DivBitsPerCycle; i++) begin
			trial   = {rem_nx, quot_nx[AccW-1]};
			quot_nx = {quot_nx[AccW-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial      = trial - {1'b0, div_q};
				quot_nx[0] = 1'b1;
			end
			rem_nx = trial[PerW-1:0];
		end
	end

	// frame stepping from the whole periods and their remainder
	always_comb begin
		cur      = ({1'b0, frame_q} > last_w) ? last8 : frame_q;
		r9       = rem_q[CntW-1:0];
		fwd0     = fwd_q;
		if (cur == '0) begin
			fwd0 = 1'b1;
		end else if (cur == last8) begin
			fwd0 = 1'b0;
		end
		ph       = fwd0 ? {1'b0, cur} : (cyc - {1'b0, cur});
		ph_sum   = {1'b0, ph} + {1'b0, r9};
		ph2      = (ph_sum >= {1'b0, cyc}) ? CntW'(ph_sum - {1'b0, cyc}) : ph_sum[CntW-1:0];
		back_pos = cyc - ph2;
		rep_sum  = {2'b00, cur} + {1'b0, r9};
		rep_red  = (rep_sum >= {1'b0, n}) ? (rep_sum - {1'b0, n}) : rep_sum;
		gap      = last8 - cur;
		new_fwd  = fwd_q;
		if (cfg.bounce_mode) begin
			if (ph2 < {1'b0, last8}) begin
				new_frame = ph2[FrW-1:0];
				new_fwd   = 1'b1;
			end else begin
				new_frame = back_pos[FrW-1:0];
				new_fwd   = 1'b0;
			end
		end else if (cfg.repeat_mode) begin
			new_frame = rep_red[FrW-1:0];
		end else if (fwd_q) begin
			new_frame = (steps_q >= AccW'(gap)) ? last8 : (cur + steps_q[FrW-1:0]);
		end else begin
			new_frame = (steps_q >= AccW'(cur)) ? '0 : (cur - steps_q[FrW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_accum_q <= '0;
			frame_q      <= '0;
			fwd_q        <= 1'b1;
			done_q       <= 1'b0;
			upd_q        <= 1'b0;
			vanish_q     <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				upd_q    <= 1'b0;
				vanish_q <= 1'b0;
			end
			if (cmd.eval) begin
				case (op_q)
					sfas_pkg::OP_TICK: begin
						if (tick_live) begin
							if (ended) begin
								vanish_q <= cfg.vanish_on_end;
								if (n > CntW'(1)) begin
									done_q <= 1'b1;
								end
							end else begin
								time_accum_q <= acc;
							end
						end
					end
					sfas_pkg::OP_REWIND: begin
						frame_q <= '0;
						fwd_q   <= 1'b1;
						upd_q   <= (n != '0);
					end
					sfas_pkg::OP_JUMP_END: begin
						frame_q <= (n != '0) ? last8 : '0;
						fwd_q   <= 1'b0;
						upd_q   <= (n != '0);
					end
					sfas_pkg::OP_SET_DIR: fwd_q <= dir_q;
					default: fwd_q <= dir_q;
				endcase
			end
			if (cmd.acc_done) begin
				time_accum_q <= AccW'(rem_nx);
			end
			if (cmd.step_commit) begin
				frame_q <= new_frame;
				fwd_q   <= new_fwd;
				upd_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q      <= opcode;
			elapsed_q <= elapsed_ticks & TickMask;
			dir_q     <= direction_forward;
		end
		if (cmd.div_load_acc) begin
			dq_q  <= acc;
			rem_q <= '0;
			div_q <= per;
		end else if (cmd.div_load_mod) begin
			dq_q  <= steps_q;
			rem_q <= '0;
			div_q <= cfg.bounce_mode ? PerW'(cyc) : PerW'(n);
		end else if (cmd.div_step) begin
			dq_q  <= quot_nx;
			rem_q <= rem_nx;
		end
		if (cmd.acc_done) begin
			steps_q <= quot_nx;
		end
		if (cmd.emit) begin
			out_frame_q    <= frame_q;
			out_finished_q <= done_q;
			out_vanish_q   <= vanish_q;
			out_updated_q  <= upd_q;
		end
	end

	assign frame_index    = out_frame_q;
	assign finished       = out_finished_q;
	assign vanish_request = out_vanish_q;
	assign frame_updated  = out_updated_q;

endmodule

/* src/sprite_frame_animation_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_frame_animation_sequencer
// Advances a sprite's animation frame index from tick and control items.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the next is taken as soon as the previous
// one has reached the output register, even if that result is still waiting
// to be taken. Rewind, jump-to-end, set-direction and ticks that do not cross
// a frame period go through the evaluate and emit states only, and their
// result is presented when the input also reopens. A tick that crosses a
// frame period runs the shared divider (2 quotient bits per cycle): in
// one-shot mode it divides once, while repeat or bounce mode need a second
// division to reduce the step count. A result still waiting in the output
// register holds the following item in its emit state until it is taken.
// The user must write configuration over the APB port only while idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module sprite_frame_animation_sequencer #(
	parameter int MAX_FRAMES = sfas_pkg::MaxFramesDef,
	parameter int TICK_WIDTH = sfas_pkg::TickWidthDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sfas_in_if.sink                     in_ch,
	sfas_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfas_pkg::AddrW-1:0]  paddr,
	input  logic [sfas_pkg::DataW-1:0]  pwdata,
	output logic [sfas_pkg::DataW-1:0]  prdata,
	output logic                        pready
);

	sfas_pkg::cfg_t cfg;
	sfas_pkg::cmd_t cmd;
	sfas_pkg::sts_t sts;

	sfas_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sfas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sfas_dpath #(
		.MAX_FRAMES (MAX_FRAMES),
		.TICK_WIDTH (TICK_WIDTH)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.sts               (sts),
		.opcode            (in_ch.opcode),
		.elapsed_ticks     (in_ch.elapsed_ticks),
		.direction_forward (in_ch.direction_forward),
		.frame_index       (out_ch.frame_index),
		.finished          (out_ch.finished),
		.vanish_request    (out_ch.vanish_request),
		.frame_updated     (out_ch.frame_updated)
	);

`ifndef SYNTHESIS
	// one item in flight: input closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("item accepted while another is in flight");

	a_vanish_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.vanish_request |-> !out_ch.frame_updated)
		else $error("vanish request on an item that stepped the frame");

	a_vanish_configured: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.vanish_request |-> cfg.vanish_on_end)
		else $error("vanish request without vanish_on_end");
`endif

endmodule
